// ===== rtl/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// shared types and constants of the utf-8 to utf-16 transcoder
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam logic [15:0] REPLACEMENT = 16'hFFFD;

    // what one input word leaves for the back end: replacements first, then main units
    typedef struct packed {
        logic [1:0]  repl;      // leading u+fffd count, 0..3
        logic [1:0]  main_cnt;  // main units after them, 0..2
        logic [15:0] unit0;
        logic [15:0] unit1;
        logic        last;      // word closes the string
    } bundle_t;

    // queue status towards the front end
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== rtl/u8u16_byte_if.sv =====
// ----------------------------------------------------------------------------
// u8u16_byte_if
// valid/ready channel carrying one utf-8 byte per word
// ----------------------------------------------------------------------------
interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// ===== rtl/u8u16_unit_if.sv =====
// ----------------------------------------------------------------------------
// u8u16_unit_if
// valid/ready channel carrying one utf-16 code unit per word
// ----------------------------------------------------------------------------
interface u8u16_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_unit;

    modport source (output valid, output code_unit, output last_unit, input ready);
    modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

// ===== rtl/u8u16_front.sv =====
// ----------------------------------------------------------------------------
// u8u16_front
// takes utf-8 bytes, tracks the pending sequence, classifies each byte
// ----------------------------------------------------------------------------
module u8u16_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    u8u16_byte_if.sink              bytes,
    input  u8u16_pkg::queue_status_t status,
    output logic                    push,
    output u8u16_pkg::bundle_t      bundle
);

    logic [7:0]  lead_reg;
    logic [7:0]  lead_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic [7:0]  tail0_reg;
    logic [7:0]  tail1_reg;
    logic        accept;

    logic [7:0]  b;
    logic        last;
    logic [2:0]  need;
    logic [2:0]  lead_len;
    logic        follow_ok;
    logic        lead_emit;
    logic        lead_hold;
    logic [15:0] lead_unit;
    logic [20:0] cp;
    logic [20:0] cp_off;
    logic        store_tail;

    function automatic logic [2:0] seq_len(input logic [7:0] x);
        logic [2:0] n;
        n = 3'd0;
        if (x inside {[8'hC2:8'hDF]})
            n = 3'd2;
        else if (x inside {[8'hE0:8'hEF]})
            n = 3'd3;
        else if (x inside {[8'hF0:8'hF4]})
            n = 3'd4;
        return n;
    endfunction

    assign b           = bytes.in_byte;
    assign last        = bytes.last_byte;
    assign bytes.ready = !status.full;
    assign accept      = bytes.valid && bytes.ready;

    assign need     = seq_len(lead_reg);
    assign lead_len = seq_len(b);

    // narrowed second-byte ranges
    always_comb
    begin
        follow_ok = (b[7:6] == 2'b10);
        if (cnt_reg == 2'd1)
        begin
            if ((lead_reg == 8'hE0 && b < 8'hA0) || (lead_reg == 8'hED && b > 8'h9F) ||
                (lead_reg == 8'hF0 && b < 8'h90) || (lead_reg == 8'hF4 && b > 8'h8F))
                follow_ok = 1'b0;
        end
    end

    // byte taken as a fresh lead
    always_comb
    begin
        lead_emit = 1'b1;
        lead_hold = 1'b0;
        lead_unit = u8u16_pkg::REPLACEMENT;
        if (!b[7])
            lead_unit = {8'h00, b};
        else if (lead_len != 3'd0 && !last)
        begin
            lead_emit = 1'b0;
            lead_hold = 1'b1;
        end
    end

    always_comb
    begin
        case (need)
            3'd2:    cp = {10'd0, lead_reg[4:0], b[5:0]};
            3'd3:    cp = {5'd0, lead_reg[3:0], tail0_reg[5:0], b[5:0]};
            3'd4:    cp = {lead_reg[2:0], tail0_reg[5:0], tail1_reg[5:0], b[5:0]};
            default: cp = 21'd0;
        endcase
    end

    assign cp_off = cp - 21'h10000;

    always_comb
    begin
        bundle.repl     = 2'd0;
        bundle.main_cnt = 2'd0;
        bundle.unit0    = lead_unit;
        bundle.unit1    = 16'h0000;
        bundle.last     = last;
        lead_next       = lead_reg;
        cnt_next        = cnt_reg;
        store_tail      = 1'b0;

        if (cnt_reg == 2'd0 || need == 3'd0 || {1'b0, cnt_reg} >= need || !follow_ok)
        begin
            // flush what is held, then the byte starts over
            bundle.repl     = cnt_reg;
            bundle.main_cnt = lead_emit ? 2'd1 : 2'd0;
            cnt_next        = lead_hold ? 2'd1 : 2'd0;
            lead_next       = lead_hold ? b : 8'h00;
        end
        else if ({1'b0, cnt_reg} + 3'd1 == need)
        begin
            // sequence complete
            cnt_next  = 2'd0;
            lead_next = 8'h00;
            if (cp[20:16] != 5'd0)
            begin
                bundle.main_cnt = 2'd2;
                bundle.unit0    = {6'b110110, cp_off[19:10]};
                bundle.unit1    = {6'b110111, cp_off[9:0]};
            end
            else
            begin
                bundle.main_cnt = 2'd1;
                bundle.unit0    = cp[15:0];
            end
        end
        else if (last)
        begin
            // cut off by end of string
            bundle.repl     = cnt_reg;
            bundle.main_cnt = 2'd1;
            bundle.unit0    = u8u16_pkg::REPLACEMENT;
            cnt_next        = 2'd0;
            lead_next       = 8'h00;
        end
        else
        begin
            store_tail = 1'b1;
            cnt_next   = cnt_reg + 2'd1;
        end

        if (last)
        begin
            cnt_next  = 2'd0;
            lead_next = 8'h00;
        end
    end

    assign push = accept && (bundle.repl != 2'd0 || bundle.main_cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= 8'h00;
            cnt_reg  <= 2'd0;
        end
        else if (accept)
        begin
            lead_reg <= lead_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_tail)
        begin
            if (cnt_reg == 2'd1)
                tail0_reg <= b;
            else
                tail1_reg <= b;
        end
    end

endmodule

// ===== rtl/u8u16_queue.sv =====
// ----------------------------------------------------------------------------
// u8u16_queue
// small fifo of classified words between front and back end
// ----------------------------------------------------------------------------
module u8u16_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  u8u16_pkg::bundle_t       wr_data,
    input  logic                     pop,
    output u8u16_pkg::bundle_t       head,
    output u8u16_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u8u16_pkg::bundle_t  store_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/u8u16_back.sv =====
// ----------------------------------------------------------------------------
// u8u16_back
// expands queued words into code units, one per cycle while units.ready does not stall it, into an output register
// ----------------------------------------------------------------------------
module u8u16_back
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  u8u16_pkg::bundle_t       head,
    input  u8u16_pkg::queue_status_t status,
    output logic                     pop,
    u8u16_unit_if.source             units
);

    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] code_unit_reg;
    logic        last_unit_reg;
    logic [2:0]  total;
    logic        is_final;
    logic        take;
    logic [1:0]  main_idx;
    logic [15:0] unit_sel;

    assign total    = {1'b0, head.repl} + {1'b0, head.main_cnt};
    assign is_final = ({1'b0, idx_reg} == total - 3'd1);
    assign take     = !status.empty && (!out_valid_reg || units.ready);
    assign pop      = take && is_final;
    assign main_idx = idx_reg - head.repl;

    always_comb
    begin
        if (idx_reg < head.repl)
            unit_sel = u8u16_pkg::REPLACEMENT;
        else if (main_idx == 2'd0)
            unit_sel = head.unit0;
        else
            unit_sel = head.unit1;
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            idx_next       = is_final ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (units.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            code_unit_reg <= unit_sel;
            last_unit_reg <= head.last && is_final;
        end
    end

    assign units.valid     = out_valid_reg;
    assign units.code_unit = code_unit_reg;
    assign units.last_unit = last_unit_reg;

endmodule

// ===== rtl/utf8_to_utf16_transcoder_unit.sv =====
// path: an accepted byte's code units are written into the queue, then registered at the output
// throughput: one byte per cycle while the queue is not full and each byte yields at most one code unit;
//   the output side gives one code unit per cycle while units.ready is high, so bytes yielding several units
//   (surrogate pairs, flushed replacements) are absorbed by the QUEUE_DEPTH-word queue
// reset: asynchronous active-low, clears the pending sequence, queue and output register
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit
// utf-8 byte stream in, utf-16 code unit stream out, with replacement on bad input
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    u8u16_byte_if.sink   bytes,
    u8u16_unit_if.source units
);

    // front end: decode state and per-byte classification
    // queue: words holding up to four code units each
    // back end: one code unit per cycle into the output register, while units.ready does not stall it

    u8u16_pkg::bundle_t       bundle;
    u8u16_pkg::bundle_t       head;
    u8u16_pkg::queue_status_t status;
    logic                     push;
    logic                     pop;

    // front end stalls only when the queue is full
    u8u16_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (bytes),
        .status (status),
        .push   (push),
        .bundle (bundle)
    );

    // words that produce nothing (a held lead or continuation) never enter the queue
    u8u16_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (bundle),
        .pop     (pop),
        .head    (head),
        .status  (status)
    );

    // back end pops a word in the cycle its final code unit is loaded into the output register
    u8u16_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .status (status),
        .pop    (pop),
        .units  (units)
    );

endmodule
